// ----- hw/rtl/wildcard_glob_matcher_macros.svh -----
// assertion macros for the glob matcher
`ifndef WILDCARD_GLOB_MATCHER_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WGM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("glob matcher check failed");

// next-cycle implication, disabled while reset is asserted
`define WGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("glob matcher check failed");

`endif

// ----- hw/rtl/wgm_pkg.sv -----
// shared constants of the glob matcher
package wgm_pkg;

	// item kinds
	localparam logic [1:0] KIND_PATTERN = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_FINISH  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CAPACITY = 2'd1;
	localparam logic [1:0] ERR_ORDER    = 2'd2;

	// wildcard bytes
	localparam logic [7:0] GLOB_STAR = 8'h2A;
	localparam logic [7:0] GLOB_ONE  = 8'h3F;

endpackage

// ----- hw/rtl/wgm_if.sv -----
// valid/ready channel interfaces of the glob matcher

// input item channel
interface wgm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] character;

	modport source (output valid, output kind, output character, input ready);
	modport sink (input valid, input kind, input character, output ready);
endinterface

// result channel
interface wgm_result_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [1:0] error_code;

	modport source (output valid, output matched, output error_code, input ready);
	modport sink (input valid, input matched, input error_code, output ready);
endinterface

// ----- hw/rtl/wgm_closure.sv -----
// parallel-prefix star closure of an active position set
module wgm_closure #(
	parameter int N = 64
) (
	input  logic [N-1:0] set,
	input  logic [N-1:0] prop,
	output logic [N-1:0] closed
);

	localparam int LV = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] g_lv [LV+1];
	logic [N-1:0] p_lv [LV+1];

	// kogge-stone scan: closed[k] = set[k] | (prop[k] & closed[k-1])
	always_comb begin
		g_lv[0] = set;
		p_lv[0] = prop;
		for (int l = 0; l < LV; l++) begin
			for (int k = 0; k < N; k++) begin
				if (k >= (1 << l)) begin
					g_lv[l+1][k] = g_lv[l][k] | (p_lv[l][k] & g_lv[l][k - (1 << l)]);
					p_lv[l+1][k] = p_lv[l][k] & p_lv[l][k - (1 << l)];
				end else begin
					g_lv[l+1][k] = g_lv[l][k];
					p_lv[l+1][k] = 1'b0;
				end
			end
		end
	end

	assign closed = g_lv[LV];

endmodule

// ----- hw/rtl/wgm_step.sv -----
// lane decode, closure and next-set update for one text byte
module wgm_step
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = 63,
	parameter int N           = MAX_PATTERN + 1,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic [LEN_W-1:0] len,
	input  logic [7:0]       store [MAX_PATTERN],
	input  logic [N-1:0]     active,
	input  logic [7:0]       ch,
	output logic [N-1:0]     next,
	output logic             hit
);

	logic [N-1:0] star_eff;
	logic [N-1:0] lit_hit;
	logic [N-1:0] prop;
	logic [N-1:0] cur;

	// per-lane decode, lanes at or beyond the pattern length are dead
	always_comb begin
		star_eff = '0;
		lit_hit  = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < len) begin
				star_eff[i] = (store[i] == GLOB_STAR);
				lit_hit[i]  = (store[i] != GLOB_STAR) &&
				              ((store[i] == GLOB_ONE) || (store[i] == ch));
			end
		end
	end

	assign prop = {star_eff[N-2:0], 1'b0};

	wgm_closure #(
		.N (N)
	) u_closure (
		.set    (active),
		.prop   (prop),
		.closed (cur)
	);

	// a star keeps its position, a literal or '?' advances by one
	always_comb begin
		next[0] = cur[0] & star_eff[0];
		for (int i = 1; i < N; i++) begin
			next[i] = (cur[i] & star_eff[i]) | (cur[i-1] & lit_hit[i-1]);
		end
	end

	assign hit = cur[len];

endmodule

// ----- hw/rtl/wildcard_glob_matcher.sv -----
// top level of the glob pattern matcher
//
//  channel  | dir | payload                 | transaction
//  ---------+-----+-------------------------+------------------------------------
//  item     | in  | kind[1:0] character[7:0]| pattern byte, text byte or finish
//  result   | out | matched error_code[1:0] | one per finish item
//
// one item a cycle sustained unless a finish is stalled: an item is held in the
// input register, then its combinational update (closure scan over the active set,
// lane compares) writes the state; a finish sets the result register in that cycle
// arst_n clears the control state and the match state; the pattern store is not cleared
// only a finish waiting on a full, unread result register stalls the input side
`include "wildcard_glob_matcher_macros.svh"

module wildcard_glob_matcher
	import wgm_pkg::*;
#(
	parameter int MAX_PATTERN = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	wgm_item_if.sink    item,
	wgm_result_if.source result
);

	localparam int N     = MAX_PATTERN + 1;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// input register
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] char_s1;

	// match state
	logic [7:0]       pattern_store [MAX_PATTERN];
	logic [LEN_W-1:0] len_q;
	logic [N-1:0]     active_q;
	logic             text_q;
	logic [1:0]       err_q;

	// result register
	logic       out_valid_q;
	logic       matched_q;
	logic [1:0] error_code_q;

	logic         out_free;
	logic         fire_s1;
	logic [N-1:0] next_set;
	logic         hit;
	logic [1:0]   err_code;

	// the result slot frees when empty or drained this cycle
	assign out_free = !out_valid_q || result.ready;
	// only a finish needs the result slot
	assign fire_s1  = valid_s1 && ((kind_s1 != KIND_FINISH) || out_free);
	assign item.ready = !valid_s1 || fire_s1;

	wgm_step #(
		.MAX_PATTERN (MAX_PATTERN),
		.N           (N),
		.LEN_W       (LEN_W)
	) u_step (
		.len    (len_q),
		.store  (pattern_store),
		.active (active_q),
		.ch     (char_s1),
		.next   (next_set),
		.hit    (hit)
	);

	// capacity overflow wins over an ordering error
	always_comb begin
		if (err_q[0]) begin
			err_code = ERR_CAPACITY;
		end else if (err_q[1]) begin
			err_code = ERR_ORDER;
		end else begin
			err_code = ERR_NONE;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= item.kind;
			char_s1 <= item.character;
		end
	end

	// pattern store, written in order at the current length
	always_ff @(posedge clk) begin
		if (fire_s1 && (kind_s1 == KIND_PATTERN) && !text_q &&
		    (len_q < LEN_W'(MAX_PATTERN))) begin
			pattern_store[len_q[IDX_W-1:0]] <= char_s1;
		end
	end

	// match state update, one item per cycle unless a finish is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			active_q <= N'(1);
			text_q   <= 1'b0;
			err_q    <= 2'b00;
		end else if (fire_s1) begin
			case (kind_s1)
				KIND_PATTERN: begin
					if (text_q) begin
						err_q[1] <= 1'b1;
					end else if (len_q >= LEN_W'(MAX_PATTERN)) begin
						err_q[0] <= 1'b1;
					end else begin
						len_q <= len_q + LEN_W'(1);
					end
				end
				KIND_TEXT: begin
					// stored unclosed; closure is reapplied on every use
					active_q <= next_set;
					text_q   <= 1'b1;
				end
				KIND_FINISH: begin
					len_q    <= '0;
					active_q <= N'(1);
					text_q   <= 1'b0;
					err_q    <= 2'b00;
				end
				default: begin
					// unused kind, no effect
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && (kind_s1 == KIND_FINISH)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (kind_s1 == KIND_FINISH)) begin
			matched_q    <= hit && (err_code == ERR_NONE);
			error_code_q <= err_code;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.matched    = matched_q;
	assign result.error_code = error_code_q;

	// no position beyond the pattern end is ever active
	`WGM_ASSERT_IMP(a_active_in_range, clk, arst_n, 1'b1, ((active_q >> len_q) >> 1) == '0)
	// the length never passes the store depth
	`WGM_ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_W'(MAX_PATTERN))
	// a finish always produces a waiting result and returns the state to idle
	`WGM_ASSERT_NXT(a_finish_result, clk, arst_n, fire_s1 && (kind_s1 == KIND_FINISH), result.valid)
	`WGM_ASSERT_NXT(a_finish_clear, clk, arst_n, fire_s1 && (kind_s1 == KIND_FINISH), (len_q == '0) && !text_q && (err_q == 2'b00) && (active_q == N'(1)))

endmodule
